@@ src/rotation_matrix_to_quaternion_assert.svh @@
// assertion macros for the matrix to quaternion block
// used by the back end and the top level
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define RMQ_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define RMQ_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ src/rmq_pkg.sv @@
// types and constants for the matrix to quaternion block
// no dependencies
`timescale 1ns / 1ps
package rmq_pkg;
  localparam int unsigned QOne = 16384;
  localparam int unsigned RootW = 17;
  localparam int unsigned ArgW = 19;
  localparam int unsigned NumW = 17;
  localparam int unsigned QuoW = 32;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } matrix_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic root_invalid;
  } quat_t;

  // classified item between front and back
  typedef struct packed {
    logic [1:0] axis;
    logic invalid;
    logic [ArgW-1:0] arg;
    logic signed [NumW-1:0] n0;
    logic signed [NumW-1:0] n1;
    logic signed [NumW-1:0] n2;
  } class_t;

  localparam logic [1:0] AxisW = 2'd3;
  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;
endpackage

@@ src/rmq_front.sv @@
// front end: trace, axis choice, root argument and numerators
// depends on rmq_pkg
`timescale 1ns / 1ps
module rmq_front (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  rmq_pkg::matrix_t mat_i,
  output logic valid_o,
  output rmq_pkg::class_t cls_o
);
  logic signed [18:0] tr, a0, a1, a2, arg;
  logic signed [16:0] s12, s20, s01, p01, p02, p12;
  rmq_pkg::class_t cls_d, cls_q;
  logic valid_q;

  always_comb begin
    tr  = 19'(mat_i.m00) + 19'(mat_i.m11) + 19'(mat_i.m22);
    a0  = 19'(mat_i.m00) - 19'(mat_i.m11) - 19'(mat_i.m22) + 19'(rmq_pkg::QOne);
    a1  = 19'(mat_i.m11) - 19'(mat_i.m22) - 19'(mat_i.m00) + 19'(rmq_pkg::QOne);
    a2  = 19'(mat_i.m22) - 19'(mat_i.m00) - 19'(mat_i.m11) + 19'(rmq_pkg::QOne);
    s12 = 17'(mat_i.m12) - 17'(mat_i.m21);
    s20 = 17'(mat_i.m20) - 17'(mat_i.m02);
    s01 = 17'(mat_i.m01) - 17'(mat_i.m10);
    p01 = 17'(mat_i.m01) + 17'(mat_i.m10);
    p02 = 17'(mat_i.m02) + 17'(mat_i.m20);
    p12 = 17'(mat_i.m12) + 17'(mat_i.m21);
    cls_d = '0;
    arg = '0;
    if (tr > 0) begin
      cls_d.axis = rmq_pkg::AxisW;
      arg = tr + 19'(rmq_pkg::QOne);
      cls_d.n0 = s12; cls_d.n1 = s20; cls_d.n2 = s01;
    end else if (mat_i.m22 > mat_i.m00 && mat_i.m22 > mat_i.m11) begin
      cls_d.axis = rmq_pkg::AxisZ;
      arg = a2;
      cls_d.n0 = s01; cls_d.n1 = p02; cls_d.n2 = p12;
    end else if (mat_i.m11 > mat_i.m00) begin
      cls_d.axis = rmq_pkg::AxisY;
      arg = a1;
      cls_d.n0 = s20; cls_d.n1 = p12; cls_d.n2 = p01;
    end else begin
      cls_d.axis = rmq_pkg::AxisX;
      arg = a0;
      cls_d.n0 = s12; cls_d.n1 = p01; cls_d.n2 = p02;
    end
    cls_d.invalid = (arg <= 0);
    cls_d.arg = cls_d.invalid ? '0 : arg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q <= cls_d;
  end

  assign valid_o = valid_q;
  assign cls_o = cls_q;
endmodule

@@ src/rmq_fifo.sv @@
// short queue between front and back, registered slots
// depends on rmq_pkg
`timescale 1ns / 1ps
module rmq_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rmq_pkg::class_t data_i,
  input  logic pop_i,
  output logic valid_o,
  output rmq_pkg::class_t data_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  rmq_pkg::class_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0] cnt_q;

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    inc = (32'(p) == Depth - 1) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= inc(wr_q);
      if (pop_i) rd_q <= inc(rd_q);
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign valid_o = (cnt_q != '0);
  assign data_o = mem_q[rd_q];
endmodule

@@ src/rmq_back.sv @@
// back end: pipelined square root, restoring division, saturation
// depends on rmq_pkg and the assertion header
`timescale 1ns / 1ps
`include "rotation_matrix_to_quaternion_assert.svh"
module rmq_back (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  rmq_pkg::class_t cls_i,
  output logic valid_o,
  output rmq_pkg::quat_t quat_o
);
  localparam int unsigned SqS = rmq_pkg::RootW;
  localparam int unsigned DvS = 16;

  // square root, one result bit per stage
  logic [SqS:0] sv_q;
  rmq_pkg::class_t sc_q [SqS+1];
  logic [33:0] rem_q [SqS+1];
  logic [rmq_pkg::RootW-1:0] res_q [SqS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
    end else begin
      sv_q <= {sv_q[SqS-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    sc_q[0] <= cls_i;
    rem_q[0] <= '0;
    res_q[0] <= '0;
  end

  for (genvar s = 0; s < SqS; s++) begin : g_sq
    logic [33:0] rem_t, trial;
    always_comb begin
      rem_t = {rem_q[s][31:0],
               2'(({sc_q[s].arg, 12'd0} >> (2 * (SqS - 1 - s))) & 31'd3)};
      trial = {15'd0, res_q[s], 2'b01};
    end
    always_ff @(posedge clk_i) begin
      sc_q[s+1] <= sc_q[s];
      if (rem_t >= trial) begin
        rem_q[s+1] <= rem_t - trial;
        res_q[s+1] <= {res_q[s][rmq_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_q[s+1] <= rem_t;
        res_q[s+1] <= {res_q[s][rmq_pkg::RootW-2:0], 1'b0};
      end
    end
  end

  // three lanes of restoring division: q = (2*|n|*4096 + d) / (2d)
  logic [DvS:0] dv_q;
  rmq_pkg::class_t dc_q [DvS+1];
  logic [rmq_pkg::RootW-1:0] droot_q [DvS+1];
  logic [rmq_pkg::QuoW-1:0] num_q [3][DvS+1];
  logic [rmq_pkg::QuoW-1:0] quo_q [3][DvS+1];
  logic [rmq_pkg::QuoW:0] prm_q [3][DvS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else begin
      dv_q <= {dv_q[DvS-1:0], sv_q[SqS]};
    end
  end

  always_ff @(posedge clk_i) begin
    dc_q[0] <= sc_q[SqS];
    droot_q[0] <= res_q[SqS];
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [rmq_pkg::NumW-1:0] nsel;
    logic [rmq_pkg::NumW-1:0] mag;
    always_comb begin
      case (l)
        0: nsel = sc_q[SqS].n0;
        1: nsel = sc_q[SqS].n1;
        default: nsel = sc_q[SqS].n2;
      endcase
      mag = nsel[rmq_pkg::NumW-1] ? rmq_pkg::NumW'(-nsel) : rmq_pkg::NumW'(nsel);
    end
    always_ff @(posedge clk_i) begin
      // dividend = mag*8192 + root; root < 2^17, so 2^30 + 2^17 fits
      num_q[l][0] <= rmq_pkg::QuoW'({mag, 13'd0}) + rmq_pkg::QuoW'(res_q[SqS]);
      quo_q[l][0] <= '0;
      prm_q[l][0] <= '0;
    end
    for (genvar s = 0; s < DvS; s++) begin : g_dv
      // two quotient bits per stage
      logic [rmq_pkg::QuoW:0] r1, r2, d2;
      logic b1, b2;
      logic [rmq_pkg::QuoW:0] p1, p2;
      always_comb begin
        d2 = {15'd0, droot_q[s], 1'b0};
        p1 = {prm_q[l][s][rmq_pkg::QuoW-1:0], num_q[l][s][rmq_pkg::QuoW-1-2*s]};
        b1 = (p1 >= d2);
        r1 = b1 ? p1 - d2 : p1;
        p2 = {r1[rmq_pkg::QuoW-1:0], num_q[l][s][rmq_pkg::QuoW-2-2*s]};
        b2 = (p2 >= d2);
        r2 = b2 ? p2 - d2 : p2;
      end
      always_ff @(posedge clk_i) begin
        num_q[l][s+1] <= num_q[l][s];
        prm_q[l][s+1] <= r2;
        quo_q[l][s+1] <= {quo_q[l][s][rmq_pkg::QuoW-3:0], b1, b2};
      end
    end
  end

  for (genvar s = 0; s < DvS; s++) begin : g_dc
    always_ff @(posedge clk_i) begin
      dc_q[s+1] <= dc_q[s];
      droot_q[s+1] <= droot_q[s];
    end
  end

  // sign, saturate and place
  function automatic logic signed [15:0] sgn_sat(input logic [rmq_pkg::QuoW-1:0] q,
                                                 input logic neg);
    logic signed [15:0] r;
    if (neg) r = (q > 32'd32768) ? -16'sd32768 : 16'(-q);
    else r = (q > 32'd32767) ? 16'sd32767 : 16'(q);
    sgn_sat = r;
  endfunction

  rmq_pkg::class_t fc;
  logic signed [15:0] c0, c1, c2, rt;
  rmq_pkg::quat_t q_d, q_q;
  logic v_q;
  always_comb begin
    fc = dc_q[DvS];
    c0 = sgn_sat(quo_q[0][DvS], fc.n0[rmq_pkg::NumW-1]);
    c1 = sgn_sat(quo_q[1][DvS], fc.n1[rmq_pkg::NumW-1]);
    c2 = sgn_sat(quo_q[2][DvS], fc.n2[rmq_pkg::NumW-1]);
    rt = (droot_q[DvS] > 17'd32767) ? 16'sd32767 : 16'(droot_q[DvS]);
    q_d = '0;
    if (fc.invalid) begin
      q_d.root_invalid = 1'b1;
    end else begin
      case (fc.axis)
        rmq_pkg::AxisW: begin
          q_d.quat_w = rt; q_d.quat_x = c0; q_d.quat_y = c1; q_d.quat_z = c2;
        end
        rmq_pkg::AxisX: begin
          q_d.quat_x = rt; q_d.quat_w = c0; q_d.quat_y = c1; q_d.quat_z = c2;
        end
        rmq_pkg::AxisY: begin
          q_d.quat_y = rt; q_d.quat_w = c0; q_d.quat_z = c1; q_d.quat_x = c2;
        end
        default: begin
          q_d.quat_z = rt; q_d.quat_w = c0; q_d.quat_x = c1; q_d.quat_y = c2;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= dv_q[DvS];
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign valid_o = v_q;
  assign quat_o = q_q;

  `RMQ_ASSERT_IMPL(a_inv_zero, clk_i, rst_ni, v_q && q_q.root_invalid,
    q_q.quat_w == 0 && q_q.quat_x == 0 && q_q.quat_y == 0 && q_q.quat_z == 0)
  `RMQ_ASSERT_NEXT(a_pipe, clk_i, rst_ni, sv_q[SqS], dv_q[0])
  `RMQ_ASSERT_IMPL(a_root_min, clk_i, rst_ni, dv_q[0] && !dc_q[0].invalid,
    droot_q[0] >= 17'd64)
endmodule

@@ src/rotation_matrix_to_quaternion.sv @@
// top level of the rotation matrix to quaternion converter
// depends on rmq_pkg, rmq_front, rmq_fifo, rmq_back and the assertion header
// usage:
//   drive mat_i and raise start for one cycle per matrix; a transfer happens
//   at a rising edge with start high and busy low. busy stays low, so one
//   matrix may enter every cycle.
//   results come out on quat_o with done high for exactly one cycle each,
//   in input order. each passes the front end register, the queue, the
//   bit-serial square root pipeline, the three division lanes and one
//   output register.
//   throughput is one matrix per cycle, set by the fully pipelined root and
//   division units.
//   reset clears all valid flags; items in flight are dropped.
//   the receiver cannot stall; results are shown once and not held.
//   root_invalid marks a non positive root argument with zero components.
`timescale 1ns / 1ps
`include "rotation_matrix_to_quaternion_assert.svh"
module rotation_matrix_to_quaternion #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  rmq_pkg::matrix_t mat_i,
  output logic done,
  output rmq_pkg::quat_t quat_o
);
  logic f_valid, q_valid;
  rmq_pkg::class_t f_cls, q_cls;

  assign busy = 1'b0;

  rmq_front u_front (
    .clk_i, .rst_ni, .valid_i(start && !busy), .mat_i,
    .valid_o(f_valid), .cls_o(f_cls)
  );

  rmq_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i, .rst_ni, .push_i(f_valid), .data_i(f_cls),
    .pop_i(q_valid), .valid_o(q_valid), .data_o(q_cls)
  );

  rmq_back u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .cls_i(q_cls),
    .valid_o(done), .quat_o
  );

  `RMQ_ASSERT_IMPL(a_no_busy, clk_i, rst_ni, start, !busy)
  `RMQ_ASSERT_NEXT(a_front_q, clk_i, rst_ni, start, f_valid)
  `RMQ_ASSERT_NEXT(a_queue_drain, clk_i, rst_ni, f_valid, q_valid)
endmodule

@@ tb/rotation_matrix_to_quaternion_chk.sv @@
// checker for the rotation matrix to quaternion block: predicts each result
// from the accepted matrix and compares it with the output, in order
// depends on rmq_pkg
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_chk (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             busy,
  input  rmq_pkg::matrix_t mat_i,
  input  logic             done,
  input  rmq_pkg::quat_t   quat_i,
  output int               fail_cnt_o,
  output int               pending_cnt_o
);
  rmq_pkg::quat_t quat_q[$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // round(n * 4096 / d), ties away from zero
  function automatic logic signed [15:0] scale_div(longint n, longint d);
    longint unsigned mag, qv;
    mag = (n < 0 ? -n : n) << 12;
    qv = (mag * 2 + d) / (d * 2);
    return clamp16(n < 0 ? -longint'(qv) : longint'(qv));
  endfunction

  function automatic rmq_pkg::quat_t to_quat(rmq_pkg::matrix_t mt);
    longint m[3][3];
    longint tr, arg, root;
    logic signed [15:0] c[4];
    int i, j, k;
    rmq_pkg::quat_t r;
    m[0][0] = mt.m00; m[0][1] = mt.m01; m[0][2] = mt.m02;
    m[1][0] = mt.m10; m[1][1] = mt.m11; m[1][2] = mt.m12;
    m[2][0] = mt.m20; m[2][1] = mt.m21; m[2][2] = mt.m22;
    for (int n = 0; n < 4; n++) c[n] = '0;
    r = '0;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      root = int_sqrt((tr + rmq_pkg::QOne) << 12);
      c[0] = clamp16(root);
      c[1] = scale_div(m[1][2] - m[2][1], root);
      c[2] = scale_div(m[2][0] - m[0][2], root);
      c[3] = scale_div(m[0][1] - m[1][0], root);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      arg = m[i][i] - m[j][j] - m[k][k] + rmq_pkg::QOne;
      if (arg <= 0) begin
        r.root_invalid = 1'b1;
      end else begin
        root = int_sqrt(arg << 12);
        c[1 + i] = clamp16(root);
        c[0] = scale_div(m[j][k] - m[k][j], root);
        c[1 + j] = scale_div(m[i][j] + m[j][i], root);
        c[1 + k] = scale_div(m[i][k] + m[k][i], root);
      end
    end
    r.quat_w = c[0];
    r.quat_x = c[1];
    r.quat_y = c[2];
    r.quat_z = c[3];
    return r;
  endfunction

  assign pending_cnt_o = quat_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    rmq_pkg::quat_t exp_q;
    if (!rst_ni) begin
      fail_cnt_o <= 0;
    end else begin
      if (start && !busy) quat_q.push_back(to_quat(mat_i));
      if (done) begin
        if (quat_q.size() == 0) begin
          if (fail_cnt_o < 10) $display("unexpected result %h", quat_i);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          exp_q = quat_q.pop_front();
          if (exp_q !== quat_i) begin
            if (fail_cnt_o < 10)
              $display({"mismatch: exp w=%0d x=%0d y=%0d z=%0d inv=%0b",
                        " got w=%0d x=%0d y=%0d z=%0d inv=%0b"},
                exp_q.quat_w, exp_q.quat_x, exp_q.quat_y, exp_q.quat_z,
                exp_q.root_invalid,
                quat_i.quat_w, quat_i.quat_x, quat_i.quat_y, quat_i.quat_z,
                quat_i.root_invalid);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/rotation_matrix_to_quaternion_tb.sv @@
// testbench top for the rotation matrix to quaternion block: drives directed
// and random matrices and gives the verdict
// depends on rmq_pkg, rotation_matrix_to_quaternion and its checker
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_tb;
  localparam int WatchLimit = 2000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  rmq_pkg::matrix_t mat_i = '0;
  logic             done;
  rmq_pkg::quat_t   quat_o;
  int               fail_cnt, pending_cnt;
  int               idle_cnt = 0;
  int               gap_pct = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  rotation_matrix_to_quaternion u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .mat_i(mat_i), .done(done), .quat_o(quat_o)
  );

  rotation_matrix_to_quaternion_chk u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .mat_i(mat_i),
    .done(done), .quat_i(quat_o), .fail_cnt_o(fail_cnt),
    .pending_cnt_o(pending_cnt)
  );

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((start && !busy) || done || !rst_ni) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WatchLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  function automatic logic signed [15:0] rnd_elem();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(-16384 + $urandom_range(0, 32768));
      default: return 16'($urandom);
    endcase
  endfunction

  // a near rotation: permuted signed unit axes plus small noise
  function automatic rmq_pkg::matrix_t rnd_rot();
    logic signed [15:0] e[9];
    int perm[3];
    int a, t;
    perm = '{0, 1, 2};
    for (a = 2; a > 0; a--) begin
      t = $urandom_range(0, a);
      {perm[a], perm[t]} = {perm[t], perm[a]};
    end
    for (a = 0; a < 9; a++) e[a] = 16'($signed($urandom_range(0, 4000)) - 2000);
    for (a = 0; a < 3; a++)
      e[a * 3 + perm[a]] = ($urandom_range(0, 1) ? 16'sd1 : -16'sd1) *
                           16'(16384 - $urandom_range(0, 6000));
    return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
  endfunction

  task automatic send(rmq_pkg::matrix_t m);
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    mat_i <= m;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  function automatic rmq_pkg::matrix_t diag(int a, int b, int c);
    rmq_pkg::matrix_t m;
    m = '0;
    m.m00 = 16'(a);
    m.m11 = 16'(b);
    m.m22 = 16'(c);
    return m;
  endfunction

  initial begin
    rmq_pkg::matrix_t m;
    int n;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // identity, half turns about each axis, ties and extreme values
    send(diag(16384, 16384, 16384));
    send(diag(16384, -16384, -16384));
    send(diag(-16384, 16384, -16384));
    send(diag(-16384, -16384, 16384));
    send(diag(0, 0, 0));
    send(diag(-16384, -16384, -16384));
    send(diag(-32768, -32768, -32768));
    send(diag(32767, 32767, 32767));
    send(diag(5000, 5000, -10000));
    send(diag(-100, 50, 50));
    send(diag(-32768, 32767, 32767));
    send({16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
          16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
    send({16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh0001,
          16'sh8000, 16'sh7fff, 16'sh8000, -16'sh8000});
    m = diag(1, 0, 0);
    m.m12 = 16'sh7fff; m.m21 = 16'sh8000; m.m01 = 16'sh7fff; m.m10 = 16'sh8000;
    send(m);
    m = diag(-16384, -16384, 16383);
    m.m01 = 16'sh7fff; m.m10 = 16'sh7fff; m.m02 = 16'sh8000; m.m20 = 16'sh8000;
    send(m);
    send('1);
    for (n = 0; n < 1000; n++) begin
      if (n == 333) gap_pct = 68;
      else if (n == 666) gap_pct = 0;
      else if (n == 0) gap_pct = 22;
      m = ($urandom_range(0, 3) != 0) ? rnd_rot() :
          {rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem(),
           rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem()};
      send(m);
    end
    start <= 1'b0;
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
